// ===== hdl/jscb_pkg.sv =====
// Shared types and constants for the joystick serial-to-CAN bridge.
// Used by the front end, the command queue, the frame builder and the top level.
`timescale 1ns / 1ps
`default_nettype none

package jscb_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 64;

  localparam logic [0:0] CFG_FAILSAFE_LIMIT = 1'd0;
  localparam logic [0:0] CFG_KEY_STEP       = 1'd1;

  localparam logic [0:0] OP_BYTE = 1'b0;
  localparam logic [0:0] OP_TICK = 1'b1;

  localparam logic [7:0] KEY_J = 8'h6A;
  localparam logic [7:0] KEY_W = 8'h77;
  localparam logic [7:0] KEY_S = 8'h73;
  localparam logic [7:0] KEY_D = 8'h64;
  localparam logic [7:0] KEY_A = 8'h61;

  localparam logic [7:0] FAILSAFE_RESET = 8'd10;
  localparam logic [6:0] KEY_STEP_RESET = 7'd16;

  localparam logic [5:0] RAMP_RESET = 6'h25;
  localparam logic [5:0] RAMP_START = 6'h20;
  localparam logic [5:0] RAMP_FLOOR = 6'h23;
  localparam logic [5:0] RAMP_TOP   = 6'h25;

  localparam logic [7:0] BYTE_CMD_HI  = 8'hB0;
  localparam logic [7:0] BYTE_NMT     = 8'h30;
  localparam logic [7:0] BYTE_NODE    = 8'h01;
  localparam logic [7:0] BYTE_KEEP    = 8'h20;
  localparam logic [7:0] BYTE_GO      = 8'h23;
  localparam logic [7:0] BYTE_ENABLE  = 8'h0F;
  localparam logic [7:0] BYTE_FWD_TAG = 8'h03;
  localparam logic [7:0] BYTE_TRN_TAG = 8'h02;

  localparam logic [2:0] LEN_SHORT = 3'd3;
  localparam logic [2:0] LEN_CMD   = 3'd4;
  localparam logic [2:0] LEN_DRIVE = 3'd7;

  localparam logic [1:0] SU_KEEP = 2'd0;
  localparam logic [1:0] SU_GO1  = 2'd1;
  localparam logic [1:0] SU_CMD  = 2'd2;
  localparam logic [1:0] SU_GO2  = 2'd3;

  typedef enum logic [1:0] {
    KIND_KEEP    = 2'd0,
    KIND_STARTUP = 2'd1,
    KIND_DRIVE   = 2'd2
  } jscb_kind_e;

  typedef struct packed {
    jscb_kind_e kind;
    logic [7:0] ramp;
    logic [7:0] fwd;
    logic [7:0] turn;
  } jscb_desc_t;

endpackage

`default_nettype wire

// ===== hdl/jscb_front.sv =====
// Front end: accepts bytes and ticks, keeps the joystick state and config registers.
// Each tick becomes one frame request for the queue. Depends on jscb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jscb_front import jscb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       accept_i,
  input  wire logic [0:0] opcode_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            push_o,
  output jscb_desc_t      push_data_o
);

  logic [7:0]  limit_q, limit_d;
  logic [6:0]  step_q, step_d;
  logic        drive_q, drive_d;
  logic        armed_q, armed_d;
  logic        await_q, await_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] fwd_q, fwd_d;
  logic [15:0] turn_q, turn_d;
  logic [5:0]  ramp_q, ramp_d;
  logic [7:0]  fs_q, fs_d;

  logic [6:0]  pair_f;
  logic [5:0]  pair_t;
  logic        pair_ok;
  logic [7:0]  fs_inc;
  logic        decay;
  logic [15:0] fwd_dec, turn_dec;

  function automatic logic [15:0] sat_step(input logic [15:0] pos, input logic [6:0] stp,
                                           input logic sub);
    logic [16:0] sum;
    begin
      if (sub) begin
        sum = {pos[15], pos} - {10'd0, stp};
      end else begin
        sum = {pos[15], pos} + {10'd0, stp};
      end
      if (sum[16] != sum[15]) begin
        sat_step = sub ? 16'h8000 : 16'h7FFF;
      end else begin
        sat_step = sum[15:0];
      end
    end
  endfunction

  function automatic logic [15:0] to_zero(input logic [15:0] pos);
    begin
      if (pos[15]) begin
        to_zero = pos + 16'd1;
      end else if (pos != 16'd0) begin
        to_zero = pos - 16'd1;
      end else begin
        to_zero = pos;
      end
    end
  endfunction

  assign pair_f  = held_q[6:0];
  assign pair_t  = rx_byte_i[6:1];
  assign pair_ok = (^pair_f) ^ (^pair_t) ^ rx_byte_i[0];

  assign fs_inc   = (fs_q == 8'hFF) ? fs_q : fs_q + 8'd1;
  assign decay    = fs_inc > limit_q;
  assign fwd_dec  = decay ? to_zero(fwd_q) : fwd_q;
  assign turn_dec = decay ? to_zero(turn_q) : turn_q;

  always_comb begin
    limit_d     = limit_q;
    step_d      = step_q;
    drive_d     = drive_q;
    armed_d     = armed_q;
    await_d     = await_q;
    held_d      = held_q;
    fwd_d       = fwd_q;
    turn_d      = turn_q;
    ramp_d      = ramp_q;
    fs_d        = fs_q;
    push_o      = 1'b0;
    push_data_o = '{kind: KIND_KEEP, ramp: 8'd0, fwd: 8'd0, turn: 8'd0};

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FAILSAFE_LIMIT: limit_d = cfg_data_i;
        CFG_KEY_STEP:       step_d  = cfg_data_i[6:0];
        default: ;
      endcase
    end

    if (accept_i && opcode_i == OP_TICK) begin
      fs_d   = fs_inc;
      fwd_d  = fwd_dec;
      turn_d = turn_dec;
      push_o = 1'b1;
      if (!drive_q) begin
        push_data_o.kind = KIND_KEEP;
      end else if (armed_q) begin
        push_data_o.kind = KIND_STARTUP;
        ramp_d  = RAMP_START;
        armed_d = 1'b0;
      end else begin
        push_data_o.kind = KIND_DRIVE;
        push_data_o.ramp = {2'd0, (ramp_q < RAMP_FLOOR) ? RAMP_FLOOR : ramp_q};
        push_data_o.fwd  = fwd_dec[7:0];
        push_data_o.turn = turn_dec[7:0];
        if (ramp_q < RAMP_TOP) begin
          ramp_d = ramp_q + 6'd1;
        end
      end
    end else if (accept_i && rx_byte_i != 8'd0) begin
      if (rx_byte_i[7]) begin
        await_d = 1'b1;
        held_d  = rx_byte_i;
      end else if (await_q) begin
        await_d = 1'b0;
        if (pair_ok) begin
          fs_d   = 8'd0;
          fwd_d  = (pair_f > 7'h40) ? {9'h1FF, pair_f} : {9'h000, pair_f};
          turn_d = (pair_t > 6'h20) ? {10'h3FF, pair_t} : {10'h000, pair_t};
        end
      end else begin
        case (rx_byte_i)
          KEY_J: begin
            drive_d = !drive_q;
            if (!drive_q) begin
              armed_d = 1'b1;
            end
          end
          KEY_W:   fwd_d  = sat_step(fwd_q, step_q, 1'b0);
          KEY_S:   fwd_d  = sat_step(fwd_q, step_q, 1'b1);
          KEY_D:   turn_d = sat_step(turn_q, step_q, 1'b0);
          KEY_A:   turn_d = sat_step(turn_q, step_q, 1'b1);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= FAILSAFE_RESET;
      step_q  <= KEY_STEP_RESET;
      drive_q <= 1'b1;
      armed_q <= 1'b0;
      await_q <= 1'b0;
      held_q  <= 8'd0;
      fwd_q   <= 16'd0;
      turn_q  <= 16'd0;
      ramp_q  <= RAMP_RESET;
      fs_q    <= 8'd0;
    end else begin
      limit_q <= limit_d;
      step_q  <= step_d;
      drive_q <= drive_d;
      armed_q <= armed_d;
      await_q <= await_d;
      held_q  <= held_d;
      fwd_q   <= fwd_d;
      turn_q  <= turn_d;
      ramp_q  <= ramp_d;
      fs_q    <= fs_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/jscb_queue.sv =====
// Short queue of frame requests between the front end and the frame builder.
// Depth comes from jscb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jscb_queue import jscb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire jscb_desc_t  push_data_i,
  input  wire logic        pop_i,
  output logic             full_o,
  output logic             empty_o,
  output jscb_desc_t       head_o
);

  jscb_desc_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d;
  logic [QPTR_W-1:0]   rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/jscb_back.sv =====
// Frame builder: expands each queued request into one or four CAN frames.
// Drives the registered output stream. Depends on jscb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jscb_back import jscb_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   empty_i,
  input  wire jscb_desc_t             head_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tlast
);

  logic                   valid_q, valid_d;
  logic [TDATA_OUT_W-1:0] data_q, data_d;
  logic                   last_q, last_d;
  logic [1:0]             step_q, step_d;
  logic                   load;
  logic                   is_last;
  logic [2:0]             len;
  logic [7:0]             b0, b1, b2, b3, b4, b5, b6;

  assign load    = !valid_q || m_axis_tready;
  assign is_last = (head_i.kind != KIND_STARTUP) || (step_q == SU_GO2);

  always_comb begin
    len = LEN_SHORT;
    b0  = BYTE_CMD_HI;
    b1  = BYTE_NODE;
    b2  = BYTE_KEEP;
    b3  = 8'd0;
    b4  = 8'd0;
    b5  = 8'd0;
    b6  = 8'd0;
    case (head_i.kind)
      KIND_STARTUP: begin
        case (step_q)
          SU_KEEP: b2 = BYTE_KEEP;
          SU_CMD: begin
            len = LEN_CMD;
            b0  = BYTE_NMT;
            b2  = 8'd0;
            b3  = BYTE_ENABLE;
          end
          default: b2 = BYTE_GO;
        endcase
      end
      KIND_DRIVE: begin
        len = LEN_DRIVE;
        b2  = head_i.ramp;
        b3  = BYTE_FWD_TAG;
        b4  = head_i.fwd;
        b5  = BYTE_TRN_TAG;
        b6  = head_i.turn;
      end
      default: ;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    step_d  = step_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        data_d = {5'd0, b6, b5, b4, b3, b2, b1, b0, len};
        last_d = is_last;
        pop_o  = is_last;
        step_d = is_last ? SU_KEEP : step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= SU_KEEP;
    end else begin
      valid_q <= valid_d;
      step_q  <= step_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

  a_step_needs_startup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != SU_KEEP |-> !empty_i && head_i.kind == KIND_STARTUP)
    else $error("Burst step advanced without a startup request at the queue head.");

  a_open_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !last_q |-> step_q != SU_KEEP)
    else $error("A non-final frame is shown but the startup burst is not in progress.");

  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> data_q[2:0] == LEN_SHORT || data_q[2:0] == LEN_CMD ||
                data_q[2:0] == LEN_DRIVE)
    else $error("Frame length is not 3, 4 or 7.");

  a_pop_when_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q && last_q)
    else $error("A request left the queue without its final frame being shown.");

endmodule

`default_nettype wire

// ===== hdl/joystick_serial_to_can_bridge.sv =====
// Path: a tick accepted at the input is written into the request queue, then its first
// frame is loaded into the output register. Throughput: one input item per cycle while
// the request queue has room; a drive or keepalive tick yields one frame, a startup tick
// four frames in turn from the output register. Serial bytes produce no frames.
// Reset: asynchronous, active low; all control state returns to its power-on values at
// once (queue storage and output data are not reset), and the output stream is empty.
`timescale 1ns / 1ps
`default_nettype none

module joystick_serial_to_can_bridge import jscb_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [0:0]             cfg_idx_i,
  input  wire logic [7:0]             cfg_data_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]             s_axis_tuser,   // [0] opcode
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata,   // [2:0] frame_length, [10:3] payload_0,
                                                      // ... [58:51] payload_6, rest zero
  output logic                        m_axis_tlast
);

  logic       accept;
  logic       push;
  jscb_desc_t push_data;
  logic       pop;
  logic       full;
  logic       empty;
  jscb_desc_t head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  jscb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .opcode_i    (s_axis_tuser),
    .rx_byte_i   (s_axis_tdata),
    .push_o      (push),
    .push_data_o (push_data)
  );

  jscb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  jscb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
